/* rtl/cls_pkg.sv */
// cls_pkg: shared constants, codes and types of the cursor list store
// no dependencies; used by the interfaces, the cells, the group reducers and the top level
package cls_pkg;

  localparam int DEPTH      = 64;
  localparam int VAL_W      = 32;
  localparam int KIND_W     = 4;
  localparam int ST_W       = 2;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  // cells are reduced in groups, group results combined in a second step
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = DEPTH / GROUP;
  localparam int GSEL_W     = $clog2(GROUP);
  localparam int GIDX_W     = $clog2(NUM_GROUPS);

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 4'd0,
    K_APPEND = 4'd1,
    K_ERASE  = 4'd2,
    K_BEGIN  = 4'd3,
    K_END    = 4'd4,
    K_PREV   = 4'd5,
    K_NEXT   = 4'd6,
    K_SETPOS = 4'd7,
    K_READ   = 4'd8,
    K_FIND   = 4'd9
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_INSERT,
    CO_APPEND,
    CO_ERASE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  // broadcast from the control to every cell
  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W-1:0]       cur;
    logic [CNT_W-1:0]       cnt;
    logic [VAL_W-1:0]       value;
  } cell_ctrl_t;

  // registered result of one group of cells
  typedef struct packed {
    logic                   hit;
    logic [GSEL_W-1:0]      first;
    logic [VAL_W-1:0]       data;
  } grp_res_t;

endpackage

/* rtl/cls_in_if.sv */
// cls_in_if: operation channel of the cursor list store, valid/ready plus payload
// depends on cls_pkg
interface cls_in_if;
  logic                              valid;
  logic                              ready;
  logic [cls_pkg::KIND_W-1:0]        kind;
  logic                              clear_request;
  logic signed [cls_pkg::VAL_W-1:0]  item_value;
  logic [cls_pkg::IDX_W-1:0]         target_position;

  modport source (output valid, kind, clear_request, item_value, target_position,
                  input ready);
  modport sink   (input valid, kind, clear_request, item_value, target_position,
                  output ready);
endinterface

/* rtl/cls_out_if.sv */
// cls_out_if: result channel of the cursor list store, valid/ready plus payload
// depends on cls_pkg
interface cls_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cls_pkg::VAL_W-1:0]  read_value;
  logic [cls_pkg::IDX_W-1:0]         found_index;
  logic [cls_pkg::ST_W-1:0]          status;
  logic [cls_pkg::CNT_W-1:0]         fill_count;
  logic [cls_pkg::IDX_W-1:0]         cursor_position;

  modport source (output valid, read_value, found_index, status, fill_count,
                  cursor_position, input ready);
  modport sink   (input valid, read_value, found_index, status, fill_count,
                  cursor_position, output ready);
endinterface

/* rtl/cursor_list_store.sv */
// cursor_list_store: ordered list with a cursor, built as a row of entry cells
// depends on cls_pkg, cls_in_if, cls_out_if, cls_cell, cls_group_reduce
//
// Usage:
//   req_i carries one operation per transaction (kind, clear_request, item_value,
//   target_position); rsp_o returns exactly one result per operation with
//   read_value, found_index, status, fill_count and cursor_position.
//   An operation is latched on acceptance, applied to all cells at once in the
//   next cycle (shift, load, compare), and the group results are combined in
//   the cycle after, which loads the output register. The block takes no new
//   operation until the last one has loaded the output register; the match bits
//   and the cursor read over the cells are reduced in two levels, group
//   registers first, then the combine step.
//   The block accepts a new operation while the last result still waits in the
//   output register. If the receiver stalls, the next result waits in the
//   combine step and no further operation is accepted until it moves.
//   Reset empties the list and sets the cursor to 0 at once; entry contents are
//   not cleared, and entries at or past the fill count are never observed.
module cursor_list_store (
  input  logic      clk_i,
  input  logic      rst_ni,
  cls_in_if.sink    req_i,
  cls_out_if.source rsp_o
);
  import cls_pkg::*;

  state_e state_q, state_d;

  logic [KIND_W-1:0] op_kind_q;
  logic              op_clear_q;
  logic [VAL_W-1:0]  op_value_q;
  logic [IDX_W-1:0]  op_target_q;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  cur_q, cur_d;

  status_e           st_q, st_d;
  logic              rd_en_q, rd_en_d;
  logic              find_en_q, find_en_d;

  logic              out_valid_q;
  logic [VAL_W-1:0]  out_value_q;
  logic [IDX_W-1:0]  out_found_q;
  status_e           out_st_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [IDX_W-1:0]  out_cur_q;

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              out_load;
  logic              full, empty;

  logic [DEPTH-1:0]              match_w;
  logic [DEPTH-1:0][VAL_W-1:0]   entry_w;
  logic [DEPTH-1:0][VAL_W-1:0]   sel_w;
  grp_res_t [NUM_GROUPS-1:0]     grp_w;

  logic [VAL_W-1:0]  res_value;
  logic [IDX_W-1:0]  res_found;
  logic              res_hit;
  status_e           res_st;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept   = req_i.valid && req_i.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = entry_w[i+1];
    end
    cls_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .match_o (match_w[i]),
      .sel_o   (sel_w[i])
    );
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    cls_group_reduce u_grp (
      .clk_i   (clk_i),
      .en_i    (state_q == S_EXEC),
      .match_i (match_w[g*GROUP +: GROUP]),
      .sel_i   (sel_w[g*GROUP +: GROUP]),
      .res_o   (grp_w[g])
    );
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_kind_q   <= req_i.kind;
      op_clear_q  <= req_i.clear_request;
      op_value_q  <= req_i.item_value;
      op_target_q <= req_i.target_position;
    end
    if (state_q == S_EXEC) begin
      st_q      <= st_d;
      rd_en_q   <= rd_en_d;
      find_en_q <= find_en_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    st_d        = ST_OK;
    rd_en_d     = 1'b0;
    find_en_d   = 1'b0;
    ctrl.op     = CO_HOLD;
    ctrl.cur    = cur_q;
    ctrl.cnt    = cnt_q;
    ctrl.value  = op_value_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (op_clear_q) begin
          cnt_d = '0;
          cur_d = '0;
        end else begin
          unique case (kind_e'(op_kind_q))
            K_INSERT: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                ctrl.op = CO_INSERT;
                cnt_d   = cnt_q + CNT_W'(1);
              end
            end
            K_APPEND: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                ctrl.op = CO_APPEND;
                cnt_d   = cnt_q + CNT_W'(1);
              end
            end
            K_ERASE: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                ctrl.op = CO_ERASE;
                rd_en_d = 1'b1;
                cnt_d   = cnt_q - CNT_W'(1);
                // cursor steps back when it lands at or past the new end
                if ((cnt_q - CNT_W'(1)) <= {1'b0, cur_q} && cur_q != '0) begin
                  cur_d = cur_q - IDX_W'(1);
                end
              end
            end
            K_BEGIN: cur_d = '0;
            K_END: begin
              cur_d = empty ? '0 : IDX_W'(cnt_q - CNT_W'(1));
            end
            K_PREV: begin
              if (cur_q != '0) begin
                cur_d = cur_q - IDX_W'(1);
              end
            end
            K_NEXT: begin
              if (!empty && ({1'b0, cur_q} + CNT_W'(1)) < cnt_q) begin
                cur_d = cur_q + IDX_W'(1);
              end
            end
            K_SETPOS: begin
              if ({1'b0, op_target_q} < cnt_q) begin
                cur_d = op_target_q;
              end else begin
                st_d = ST_MISS;
              end
            end
            K_READ: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                rd_en_d = 1'b1;
              end
            end
            K_FIND: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else begin
                find_en_d = 1'b1;
              end
            end
            default: st_d = ST_OK;
          endcase
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- combine groups
  always_comb begin
    res_hit   = 1'b0;
    res_found = '0;
    res_value = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_w[g].hit) begin
        res_hit   = 1'b1;
        res_found = {GIDX_W'(g), grp_w[g].first};
      end
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      res_value = res_value | grp_w[g].data;
    end
    res_st = st_q;
    if (find_en_q && !res_hit) begin
      res_st = ST_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= rd_en_q ? res_value : '0;
      out_found_q <= (find_en_q && res_hit) ? res_found : '0;
      out_st_q    <= res_st;
      out_cnt_q   <= cnt_q;
      out_cur_q   <= cur_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.read_value      = out_value_q;
  assign rsp_o.found_index     = out_found_q;
  assign rsp_o.status          = out_st_q;
  assign rsp_o.fill_count      = out_cnt_q;
  assign rsp_o.cursor_position = out_cur_q;

`ifndef SYNTHESIS
  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_q} < cnt_q) || (cnt_q == '0 && cur_q == '0))
    else $error("cursor outside the list");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_clear_q) |=> (cnt_q == '0 && cur_q == '0))
    else $error("clear did not empty the list");
`endif

endmodule

/* rtl/cls_cell.sv */
// cls_cell: one list entry; shifts with its neighbors, loads, compares and drives its value
// depends on cls_pkg
module cls_cell (
  input  logic                        clk_i,
  input  logic [cls_pkg::IDX_W-1:0]   idx_i,
  input  cls_pkg::cell_ctrl_t         ctrl_i,
  input  logic [cls_pkg::VAL_W-1:0]   left_i,
  input  logic [cls_pkg::VAL_W-1:0]   right_i,
  output logic [cls_pkg::VAL_W-1:0]   entry_o,
  output logic                        match_o,
  output logic [cls_pkg::VAL_W-1:0]   sel_o
);
  import cls_pkg::*;

  logic [VAL_W-1:0] entry_q, entry_d;
  logic [CNT_W-1:0] idx_c;

  assign idx_c = {{(CNT_W-IDX_W){1'b0}}, idx_i};

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CO_INSERT: begin
        if (idx_i == ctrl_i.cur) begin
          entry_d = ctrl_i.value;
        end else if (idx_i > ctrl_i.cur && idx_c <= ctrl_i.cnt) begin
          entry_d = left_i;
        end
      end
      CO_APPEND: begin
        if (idx_c == ctrl_i.cnt) begin
          entry_d = ctrl_i.value;
        end
      end
      CO_ERASE: begin
        if (idx_i >= ctrl_i.cur && (idx_c + CNT_W'(1)) < ctrl_i.cnt) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == ctrl_i.value) && (idx_c < ctrl_i.cnt);
  assign sel_o   = (idx_i == ctrl_i.cur) ? entry_q : '0;

endmodule

/* rtl/cls_group_reduce.sv */
// cls_group_reduce: registers the first match and the cursor value of one group of cells
// depends on cls_pkg
module cls_group_reduce (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [cls_pkg::GROUP-1:0]              match_i,
  input  logic [cls_pkg::GROUP-1:0][cls_pkg::VAL_W-1:0] sel_i,
  output cls_pkg::grp_res_t                      res_o
);
  import cls_pkg::*;

  grp_res_t res_q, res_d;

  always_comb begin
    res_d = '0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        res_d.hit   = 1'b1;
        res_d.first = GSEL_W'(i);
      end
    end
    // at most one cell drives a nonzero value
    for (int i = 0; i < GROUP; i++) begin
      res_d.data = res_d.data | sel_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* test/tb_cursor_list_store.sv */
`timescale 1ns / 1ps
// tb_cursor_list_store: self-checking testbench for the cursor list store
// depends on cls_pkg, cls_in_if, cls_out_if and the cursor_list_store rtl
module tb_cursor_list_store;
  import cls_pkg::*;

  localparam int N_RANDOM       = 1425;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_WALK   = 2;
  localparam int MODE_MIX    = 3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic                    clear_request;
    logic signed [VAL_W-1:0] item_value;
    logic [IDX_W-1:0]        target_position;
  } list_op_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [IDX_W-1:0]        found_index;
    status_e                 status;
    logic [CNT_W-1:0]        fill_count;
    logic [IDX_W-1:0]        cursor_position;
  } list_result_t;

  // mirrors the list contents and holds the results still owed by the block
  class list_checker;
    logic [VAL_W-1:0] slots [DEPTH];
    int               count;
    int               cur;
    list_result_t     expected_results [$];
    int               mismatches;
    int               results_seen;

    function new();
      count        = 0;
      cur          = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int fill_level();
      return count;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function list_result_t apply_op(list_op_t op);
      list_result_t r;
      r.read_value  = '0;
      r.found_index = '0;
      r.status      = ST_OK;
      if (op.clear_request) begin
        count = 0;
        cur   = 0;
      end else begin
        case (op.kind)
          K_INSERT: begin
            if (count >= DEPTH) begin
              r.status = ST_FULL;
            end else begin
              for (int i = count; i > cur; i--) slots[i] = slots[i-1];
              slots[cur] = op.item_value;
              count++;
            end
          end
          K_APPEND: begin
            if (count >= DEPTH) begin
              r.status = ST_FULL;
            end else begin
              slots[count] = op.item_value;
              count++;
            end
          end
          K_ERASE: begin
            if (count == 0) begin
              r.status = ST_EMPTY;
            end else begin
              r.read_value = slots[cur];
              for (int i = cur; i + 1 < count; i++) slots[i] = slots[i+1];
              count--;
              // cursor falls back when it lands on or past the new end
              if (count <= cur && cur != 0) cur--;
            end
          end
          K_BEGIN: cur = 0;
          K_END:   cur = (count == 0) ? 0 : count - 1;
          K_PREV:  if (cur != 0) cur--;
          K_NEXT:  if (count != 0 && cur + 1 < count) cur++;
          K_SETPOS: begin
            if (op.target_position < count) cur = op.target_position;
            else r.status = ST_MISS;
          end
          K_READ: begin
            if (count == 0) r.status = ST_EMPTY;
            else r.read_value = slots[cur];
          end
          K_FIND: begin
            if (count == 0) begin
              r.status = ST_EMPTY;
            end else begin
              r.status = ST_MISS;
              for (int i = 0; i < count; i++) begin
                if (slots[i] == op.item_value) begin
                  r.found_index = IDX_W'(i);
                  r.status      = ST_OK;
                  break;
                end
              end
            end
          end
          default: ;
        endcase
      end
      r.fill_count      = CNT_W'(count);
      r.cursor_position = IDX_W'(cur);
      return r;
    endfunction

    function void note_op(list_op_t op);
      expected_results.push_back(apply_op(op));
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(list_result_t act);
      list_result_t exp;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, fill_count", act.fill_count, -1);
      end else begin
        exp = expected_results.pop_front();
        if (act.read_value !== exp.read_value)
          report_mismatch("read_value", act.read_value, exp.read_value);
        if (act.found_index !== exp.found_index)
          report_mismatch("found_index", act.found_index, exp.found_index);
        if (act.status !== exp.status)
          report_mismatch("status", act.status, exp.status);
        if (act.fill_count !== exp.fill_count)
          report_mismatch("fill_count", act.fill_count, exp.fill_count);
        if (act.cursor_position !== exp.cursor_position)
          report_mismatch("cursor_position", act.cursor_position, exp.cursor_position);
      end
      results_seen++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   stall_cycles;

  cls_in_if  req ();
  cls_out_if rsp ();

  list_checker sb = new();

  cursor_list_store u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // prediction on every accepted operation, checking on every accepted result
  always @(posedge clk_i) begin
    list_result_t act;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        act.read_value      = rsp.read_value;
        act.found_index     = rsp.found_index;
        act.status          = status_e'(rsp.status);
        act.fill_count      = rsp.fill_count;
        act.cursor_position = rsp.cursor_position;
        sb.check_result(act);
      end
      if (req.valid && req.ready)
        sb.note_op({req.kind, req.clear_request, req.item_value, req.target_position});
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: steady, patterned and random ready, plus one long hold-off
  initial begin
    int   chunk;
    int   len;
    logic [31:0] mask;
    logic v;
    bit   long_hold_done;
    long_hold_done = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      chunk = $urandom_range(0, 2);
      len   = $urandom_range(8, 60);
      mask  = $urandom;
      for (int i = 0; i < len; i++) begin
        case (chunk)
          0:       v = 1'b1;
          1:       v = mask[i % 32];
          default: v = ($urandom_range(0, 3) != 0);
        endcase
        rsp.ready <= v;
        @(posedge clk_i);
      end
      if (!long_hold_done && sb.results_seen >= 400) begin
        long_hold_done = 1'b1;
        for (int i = 0; i < LONG_HOLD; i++) begin
          rsp.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic list_op_t mk_op(logic [KIND_W-1:0] kind, logic clr,
                                     logic signed [VAL_W-1:0] value,
                                     logic [IDX_W-1:0] target);
    list_op_t op;
    op.kind            = kind;
    op.clear_request   = clr;
    op.item_value      = value;
    op.target_position = target;
    return op;
  endfunction

  // mostly values from a small pool so that finds hit and duplicates occur
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:         return 32'sh7fffffff;
      1:         return 32'sh80000000;
      2, 3, 4, 5: return $signed($urandom_range(0, 7)) - 4;
      default:   return $urandom;
    endcase
  endfunction

  function automatic list_op_t random_op(int mode);
    list_op_t op;
    int       r;
    int       fill;
    fill = sb.fill_level();
    r    = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   op.kind = (r < 45) ? K_INSERT : (r < 85) ? K_APPEND
                                      : KIND_W'($urandom_range(0, 15));
      MODE_SHRINK: op.kind = (r < 65) ? K_ERASE : KIND_W'($urandom_range(0, 15));
      MODE_WALK: begin
        case ($urandom_range(0, 6))
          0:       op.kind = K_BEGIN;
          1:       op.kind = K_END;
          2:       op.kind = K_PREV;
          3:       op.kind = K_NEXT;
          4:       op.kind = K_SETPOS;
          5:       op.kind = K_READ;
          default: op.kind = K_FIND;
        endcase
      end
      default:     op.kind = KIND_W'($urandom_range(0, 15));
    endcase
    op.clear_request   = ($urandom_range(0, 149) == 0);
    op.item_value      = pick_value();
    op.target_position = IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                : $urandom_range(0, (fill > 0) ? fill - 1 : 0));
    return op;
  endfunction

  task automatic send_op(list_op_t op);
    req.valid           <= 1'b1;
    req.kind            <= op.kind;
    req.clear_request   <= op.clear_request;
    req.item_value      <= op.item_value;
    req.target_position <= op.target_position;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic idle_for(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int mode;
    int seg_left;
    int burst_left;
    req.valid           <= 1'b0;
    req.kind            <= K_INSERT;
    req.clear_request   <= 1'b0;
    req.item_value      <= '0;
    req.target_position <= '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // operations on an empty list
    send_op(mk_op(K_READ,   1'b0, 32'sd5, 6'd0));
    send_op(mk_op(K_ERASE,  1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_FIND,   1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_END,    1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_NEXT,   1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_PREV,   1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_SETPOS, 1'b0, 32'sd0, 6'd0));
    // extremes of the value, then edges of the cursor
    send_op(mk_op(K_APPEND, 1'b0, 32'sh7fffffff, 6'd0));
    send_op(mk_op(K_APPEND, 1'b0, 32'sh80000000, 6'd0));
    send_op(mk_op(K_INSERT, 1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_APPEND, 1'b0, -32'sd1, 6'd0));
    send_op(mk_op(K_END,    1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_NEXT,   1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_READ,   1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_SETPOS, 1'b0, 32'sd0, 6'd63));
    send_op(mk_op(K_SETPOS, 1'b0, 32'sd0, 6'd1));
    send_op(mk_op(K_FIND,   1'b0, 32'sh80000000, 6'd0));
    send_op(mk_op(K_FIND,   1'b0, 32'sd12345, 6'd0));
    send_op(mk_op(K_ERASE,  1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_END,    1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_ERASE,  1'b0, 32'sd0, 6'd0));
    send_op(mk_op(K_BEGIN,  1'b0, 32'sd0, 6'd0));
    send_op(mk_op(KIND_UNUSED_LO, 1'b0, 32'sd0, 6'd0));
    send_op(mk_op(KIND_UNUSED_HI, 1'b0, 32'sd0, 6'd63));
    // clear wins over the insert that comes with it
    send_op(mk_op(K_INSERT, 1'b1, 32'sd7, 6'd0));

    seg_left   = 0;
    burst_left = 0;
    for (int sent = 0; sent < N_RANDOM; sent++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(MODE_GROW, MODE_MIX);
        seg_left = $urandom_range(20, 90);
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 20);
      end
      send_op(random_op(mode));
      seg_left--;
      burst_left--;
    end
    req.valid <= 1'b0;

    // let the monitor note the last accepted transaction first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
